// ===== hw/rtl/lcadj_pkg.sv =====
// Shared types and constants for the luma/chroma adjust pipeline.
// No dependencies; imported by lcadj_gain and video_luma_chroma_adjust.
`timescale 1ns / 1ps

package lcadj_pkg;

  // Gain factors are fixed point with UnityGain meaning a gain of one.
  localparam int unsigned GainW      = 12;
  localparam int unsigned LevelW     = 8;
  localparam int unsigned UnityGain  = 1000;
  localparam int unsigned LevelMid   = 127;
  localparam int unsigned LumaBase   = 16;
  localparam int unsigned ChromaBase = 128;
  localparam int unsigned PixMax     = 255;

  typedef logic [GainW-1:0]  gain_t;
  typedef logic [LevelW-1:0] level_t;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegBrightness = 2'd0;
  localparam logic [CfgIdxW-1:0] RegContrast   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSaturation = 2'd2;

  // Reciprocal of LevelMid: floor(n * RecipLevel / 2^LevelShift) == floor(n / 127)
  // for every numerator below 2^19.
  localparam logic [19:0] RecipLevel = 20'd528417;
  localparam int unsigned LevelShift = 26;

  // Reciprocal of 1000, exact for numerators below 2^20.
  localparam logic [20:0] RecipLuma = 21'd1073742;
  localparam int unsigned LumaShift = 30;

  // Reciprocal of 1000000, exact for numerators below 2^27.
  localparam logic [27:0] RecipChroma = 28'd140737489;
  localparam int unsigned ChromaShift = 47;

endpackage

// ===== hw/rtl/video_luma_chroma_adjust.sv =====
// Top level of the luma/chroma adjust block: config registers and a seven-stage pipeline.
// Depends on lcadj_pkg and instantiates lcadj_gain for the contrast and saturation gains.
`timescale 1ns / 1ps

// Usage
// A request is one 8-bit sample on sample_in_i, taken at a rising edge where start_i is
// high and busy_o is low. The block keeps no state between samples, so a new request can
// be taken on every clock: the pipeline is fully open and throughput is one sample per
// cycle. The result for a request appears on luma_out_o and chroma_out_o with done_o
// high once it has passed through every pipeline stage, ending in the output registers
// (the depth is set by the chain of gain lookup, two gain products and two reciprocal
// divisions). Results leave in request order and are shown for exactly one cycle; the
// receiver has no way to hold them, and none is needed since nothing backs up.
// Brightness, contrast and saturation are written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i, index 0, 1 and 2 in that order; other indexes are ignored. They should
// only change while no request is in flight. Reset is asynchronous and active low: it
// returns all three levels to 127 (neutral), drops every in-flight request, and holds
// busy_o high until the first clock edge after reset is released.
module video_luma_chroma_adjust (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [7:0]                      sample_in_i,
  output logic                            done_o,
  output logic [7:0]                      luma_out_o,
  output logic [7:0]                      chroma_out_o,
  input  logic                            cfg_we_i,
  input  logic [lcadj_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [7:0]                      cfg_wdata_i
);
  import lcadj_pkg::*;

  // Configuration registers.
  level_t brightness_q, contrast_q, saturation_q;
  logic   busy_q;

  // Valid bits, one per stage.
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, done_q;
  logic accept;

  // Stage 0/1: sample and brightness travel while the gains are formed.
  logic [7:0] x0_q, x1_q, x2_q;
  level_t     b0_q, b1_q, b2_q, b3_q, b4_q;
  gain_t      fc, fs;

  // Stage 2: luma contrast product and combined chroma gain.
  logic signed [8:0]  xl;
  logic signed [12:0] fcs;
  logic signed [21:0] pl_d, pl2_q;
  logic [23:0]        g_d, g2_q;

  // Stage 3: luma divide by 1000 and chroma product.
  logic [21:0]        lmag_full;
  logic [40:0]        lprod;
  logic [9:0]         lq3_q;
  logic               lneg3_q;
  logic signed [7:0]  xc;
  logic signed [24:0] gs;
  logic signed [32:0] pc_d, pc3_q;

  // Stage 4: luma first clamp, chroma magnitude saturation.
  logic signed [10:0] ly;
  logic [7:0]         y1_d, y4_q;
  logic [32:0]        cmag;
  logic [26:0]        nsat_d, nsat4_q;
  logic               cneg4_q;

  // Stage 5: brightness offset and chroma divide by one million.
  logic signed [10:0] y2;
  logic [7:0]         y5_d, y5_q;
  logic [54:0]        cprod;
  logic [7:0]         cq5_q;
  logic               cneg5_q;

  // Stage 6: output registers.
  logic signed [9:0]  cs;
  logic [7:0]         c_d, luma_q, chroma_q;

  assign accept = start_i && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= LevelW'(LevelMid);
      contrast_q   <= LevelW'(LevelMid);
      saturation_q <= LevelW'(LevelMid);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegBrightness: brightness_q <= cfg_wdata_i;
        RegContrast:   contrast_q   <= cfg_wdata_i;
        RegSaturation: saturation_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= 1'b0;
      v0_q   <= accept;
      v1_q   <= v0_q;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      done_q <= v5_q;
    end
  end

  // The gain units sample the level registers at the same edge as the request and
  // present the gain at the next edge, lined up with stage 1.
  lcadj_gain u_gain_contrast (
    .clk_i   (clk_i),
    .level_i (contrast_q),
    .gain_o  (fc)
  );

  lcadj_gain u_gain_saturation (
    .clk_i   (clk_i),
    .level_i (saturation_q),
    .gain_o  (fs)
  );

  always_ff @(posedge clk_i) begin
    x0_q <= sample_in_i;
    b0_q <= brightness_q;
    x1_q <= x0_q;
    b1_q <= b0_q;
  end

  // Stage 2. The luma product is at most 239 * 4023, well inside 22 bits signed.
  assign xl   = $signed({1'b0, x1_q}) - 9'sd16;
  assign fcs  = $signed({1'b0, fc});
  assign pl_d = xl * fcs;
  assign g_d  = 24'(fc) * 24'(fs);

  always_ff @(posedge clk_i) begin
    pl2_q <= pl_d;
    g2_q  <= g_d;
    x2_q  <= x1_q;
    b2_q  <= b1_q;
  end

  // Stage 3. Luma divides the magnitude so the quotient truncates toward zero.
  assign lmag_full = pl2_q[21] ? 22'(-pl2_q) : pl2_q;
  assign lprod     = 41'(lmag_full[19:0]) * 41'(RecipLuma);
  // Flipping the top bit of x gives x - 128 as a signed byte.
  assign xc        = $signed(x2_q ^ 8'h80);
  assign gs        = $signed({1'b0, g2_q});
  assign pc_d      = xc * gs;

  always_ff @(posedge clk_i) begin
    lq3_q   <= lprod[LumaShift +: 10];
    lneg3_q <= pl2_q[21];
    pc3_q   <= pc_d;
    b3_q    <= b2_q;
  end

  // Stage 4. Chroma only needs the quotient up to the clamp point, so the magnitude is
  // saturated to 27 bits; any saturated value still clamps on both sides.
  always_comb begin
    if (lneg3_q) begin
      ly = 11'sd16 - $signed({1'b0, lq3_q});
    end else begin
      ly = 11'sd16 + $signed({1'b0, lq3_q});
    end
    if (ly < 11'sd0) begin
      y1_d = 8'd0;
    end else if (ly > 11'sd255) begin
      y1_d = 8'(PixMax);
    end else begin
      y1_d = ly[7:0];
    end
  end

  assign cmag   = pc3_q[32] ? 33'(-pc3_q) : pc3_q;
  assign nsat_d = (|cmag[32:27]) ? '1 : cmag[26:0];

  always_ff @(posedge clk_i) begin
    y4_q    <= y1_d;
    nsat4_q <= nsat_d;
    cneg4_q <= pc3_q[32];
    b4_q    <= b3_q;
  end

  // Stage 5. Brightness adds 2 * (b - 127), one less again when b is below neutral.
  always_comb begin
    y2 = $signed({3'b000, y4_q}) + $signed({2'b00, b4_q, 1'b0}) - 11'sd254;
    if (b4_q < LevelW'(LevelMid)) begin
      y2 = y2 - 11'sd1;
    end
    if (y2 < 11'sd0) begin
      y5_d = 8'd0;
    end else if (y2 > 11'sd255) begin
      y5_d = 8'(PixMax);
    end else begin
      y5_d = y2[7:0];
    end
  end

  assign cprod = 55'(nsat4_q) * 55'(RecipChroma);

  always_ff @(posedge clk_i) begin
    y5_q    <= y5_d;
    cq5_q   <= cprod[ChromaShift +: 8];
    cneg5_q <= cneg4_q;
  end

  // Stage 6. Chroma is recentered on 128 and clamped.
  always_comb begin
    if (cneg5_q) begin
      cs = 10'sd128 - $signed({2'b00, cq5_q});
    end else begin
      cs = 10'sd128 + $signed({2'b00, cq5_q});
    end
    if (cs < 10'sd0) begin
      c_d = 8'd0;
    end else if (cs > 10'sd255) begin
      c_d = 8'(PixMax);
    end else begin
      c_d = cs[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    luma_q   <= y5_q;
    chroma_q <= c_d;
  end

  assign busy_o       = busy_q;
  assign done_o       = done_q;
  assign luma_out_o   = luma_q;
  assign chroma_out_o = chroma_q;

`ifndef SYNTHESIS
  // Every accepted request yields a result; done_o rises once the request's valid bit has
  // passed from v0_q through v5_q into done_q.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##7 done_o)
    else $error("accepted request produced no result");

  // Every result traces back to a request accepted earlier, through the chain of valid bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 7))
    else $error("result without a matching request");

  // The block never refuses a request once it has left reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> !busy_o)
    else $error("busy raised outside reset");
`endif

endmodule

// ===== hw/rtl/lcadj_gain.sv =====
// Two-stage gain factor unit: turns an 8-bit level into a gain in thousandths.
// Depends on lcadj_pkg for the level midpoint and the reciprocal of 127.
`timescale 1ns / 1ps

module lcadj_gain (
  input  logic               clk_i,
  input  lcadj_pkg::level_t  level_i,
  output lcadj_pkg::gain_t   gain_o
);
  import lcadj_pkg::*;

  // Stage A: numerator of the division by 127.
  logic        hi_d, hi_q;
  logic [7:0]  diff;
  logic [18:0] num_d, num_q;

  // Stage B: reciprocal multiply and unity offset.
  logic [38:0] prod;
  logic [11:0] quot;
  gain_t       gain_d, gain_q;

  assign hi_d = (level_i > LevelW'(LevelMid));
  assign diff = level_i - LevelW'(LevelMid);

  always_comb begin
    if (hi_d) begin
      num_d = 19'(diff) * 19'(3 * UnityGain);
    end else begin
      num_d = 19'(level_i) * 19'(UnityGain);
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q  <= hi_d;
    num_q <= num_d;
  end

  assign prod = 39'(num_q) * 39'(RecipLevel);
  assign quot = prod[LevelShift +: 12];

  always_comb begin
    if (hi_q) begin
      gain_d = GainW'(UnityGain) + quot;
    end else begin
      gain_d = quot;
    end
  end

  always_ff @(posedge clk_i) begin
    gain_q <= gain_d;
  end

  assign gain_o = gain_q;

endmodule

// ===== tb/sv/video_luma_chroma_adjust_tb.sv =====
// Self-checking testbench for video_luma_chroma_adjust: directed and random samples under many
// brightness, contrast and saturation levels, checked against a built-in luma/chroma predictor.
// Depends on lcadj_pkg and the video_luma_chroma_adjust RTL only.
`timescale 1ns / 1ps

module video_luma_chroma_adjust_tb;
  import lcadj_pkg::*;

  // Output byte pair for one request.
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma;
  } pixel_t;

  // The only index that maps to no register; writes to it must be dropped.
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  // Signed copies of the package constants, so that the predictor never
  // mixes unsigned operands into arithmetic that goes negative.
  localparam longint Unity  = UnityGain;
  localparam longint Mid    = LevelMid;
  localparam longint LumaB  = LumaBase;
  localparam longint ChromB = ChromaBase;
  localparam longint PixTop = PixMax;

  // Settle time after the last result, comfortably above the pipeline depth.
  localparam int unsigned SettleCycles = 10;
  // The run sends 1519 requests with short gaps plus config phases; the limit
  // leaves a wide margin over its length.
  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned RandPhases   = 10;
  localparam int unsigned PhaseSamples = 150;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [7:0]  sample_in_i;
  logic        done_o;
  logic [7:0]  luma_out_o;
  logic [7:0]  chroma_out_o;
  logic        cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [7:0]  cfg_wdata_i;

  // Predictor copy of the three level registers.
  level_t brightness_lvl;
  level_t contrast_lvl;
  level_t saturation_lvl;

  // Adjusted pixels still owed by the block, oldest first.
  pixel_t pending_pixels[$];
  pixel_t oldest_pixel;

  int unsigned failures;
  int unsigned samples_sent;
  int unsigned pixels_checked;
  int unsigned level_writes;
  int unsigned cycle_count;

  video_luma_chroma_adjust DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .sample_in_i  (sample_in_i),
    .done_o       (done_o),
    .luma_out_o   (luma_out_o),
    .chroma_out_o (chroma_out_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Fixed-point gain for a level: 1000 is unity, the range above the
  // midpoint is stretched to reach four times at full scale.
  function automatic longint level_gain(input level_t v);
    longint lv;
    lv = v;
    if (lv > Mid) begin
      return Unity + ((lv - Mid) * 3 * Unity) / Mid;
    end
    return (lv * Unity) / Mid;
  endfunction

  function automatic longint clamp_byte(input longint v);
    if (v > PixTop) begin
      return PixTop;
    end
    if (v < 0) begin
      return 0;
    end
    return v;
  endfunction

  // Predicts luma and chroma for one sample under the current levels.
  // SystemVerilog signed division truncates toward zero, as the block must.
  function automatic pixel_t adjust_pixel(input logic [7:0] sample);
    longint x;
    longint fc;
    longint fs;
    longint b;
    longint y;
    longint c;
    pixel_t px;
    x  = sample;
    fc = level_gain(contrast_lvl);
    fs = level_gain(saturation_lvl);
    b  = brightness_lvl;
    // Luma: contrast around the black level, clamp, then brightness offset.
    y = clamp_byte(((x - LumaB) * fc) / Unity + LumaB);
    y = y + (b - Mid) * 2;
    if (b < Mid) begin
      y = y - 1;
    end
    y = clamp_byte(y);
    // Chroma: saturation and contrast applied together around mid-gray.
    c = clamp_byte((((x - ChromB) * fs * fc) / Unity) / Unity + ChromB);
    px.luma   = y[7:0];
    px.chroma = c[7:0];
    return px;
  endfunction

  // Result checker. Outputs are sampled at the edge that ends the done cycle,
  // before any register update of that edge becomes visible.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_pixels.size() == 0) begin
        $error("result with no request pending: luma=%0d chroma=%0d",
               luma_out_o, chroma_out_o);
        failures++;
      end else begin
        oldest_pixel = pending_pixels.pop_front();
        pixels_checked++;
        if (luma_out_o !== oldest_pixel.luma) begin
          $error("luma_out expected %0d actual %0d", oldest_pixel.luma, luma_out_o);
          failures++;
        end
        if (chroma_out_o !== oldest_pixel.chroma) begin
          $error("chroma_out expected %0d actual %0d", oldest_pixel.chroma, chroma_out_o);
          failures++;
        end
      end
    end
  end

  // Watchdog: a hung pipeline or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_pixels.size());
      $display("[video_luma_chroma_adjust] ERROR");
      $finish;
    end
  end

  // Sends one request. start_i stays high on return so that back-to-back
  // requests never lower and raise it within the same time step; callers
  // lower it only when a gap or a drain follows.
  task automatic send_sample(input logic [7:0] sample);
    start_i     <= 1'b1;
    sample_in_i <= sample;
    do begin
      @(posedge clk_i);
    end while (busy_o);
    // Accepted at this edge, so the prediction uses the levels in force now.
    pending_pixels.push_back(adjust_pixel(sample));
    samples_sent++;
  endtask

  // Sender gap of the given length; the data bus carries junk meanwhile.
  task automatic sender_gap(input int unsigned cycles);
    if (cycles > 0) begin
      start_i     <= 1'b0;
      sample_in_i <= 8'($urandom);
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Stops sending and waits until every owed result has been checked, then
  // lets the pipeline run empty so that level writes cannot touch a request.
  task automatic drain_pipeline();
    start_i <= 1'b0;
    while (pending_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One level register write; the block must be idle when this is called.
  task automatic write_level(input logic [CfgIdxW-1:0] idx, input level_t value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      RegBrightness: brightness_lvl = value;
      RegContrast:   contrast_lvl   = value;
      RegSaturation: saturation_lvl = value;
      default: ;
    endcase
    level_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all_levels(input level_t b, input level_t c, input level_t s);
    write_level(RegBrightness, b);
    write_level(RegContrast, c);
    write_level(RegSaturation, s);
  endtask

  // Levels lean toward the ends and the neutral point, where the gain rule
  // and the brightness offset change form.
  function automatic level_t pick_level();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd127;
      3:       return 8'($urandom_range(120, 134));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 8'($urandom_range(0, 1) ? 255 : 0);
      1:       return 8'($urandom_range(12, 20));
      2:       return 8'($urandom_range(124, 132));
      default: return 8'($urandom);
    endcase
  endfunction

  // Reset levels (all neutral) with the sample extremes, the black level,
  // mid-gray and alternating bit patterns.
  task automatic test_neutral_levels();
    send_sample(8'd0);
    send_sample(8'd255);
    send_sample(8'd16);
    send_sample(8'd128);
    send_sample(8'h55);
    send_sample(8'hAA);
    drain_pipeline();
  endtask

  // Level extremes: full gain with darkest brightness pushes both clamps,
  // zero gain with brightest brightness collapses everything to one value.
  task automatic test_level_extremes();
    write_all_levels(8'd0, 8'd255, 8'd255);
    send_sample(8'd0);
    send_sample(8'd255);
    send_sample(8'd128);
    send_sample(8'd16);
    drain_pipeline();
    write_all_levels(8'd255, 8'd0, 8'd0);
    send_sample(8'd0);
    send_sample(8'd255);
    send_sample(8'd77);
    drain_pipeline();
    // Brightness one below neutral takes the extra minus one; contrast and
    // saturation one step either side of unity use the two gain rules.
    write_all_levels(8'd126, 8'd128, 8'd126);
    send_sample(8'd1);
    send_sample(8'd200);
    send_sample(8'd129);
    drain_pipeline();
  endtask

  // A write to the unused index must leave every level as it was.
  task automatic test_unused_index();
    write_level(RegUnused, 8'd0);
    write_level(RegUnused, 8'd255);
    send_sample(8'd40);
    send_sample(8'd180);
    send_sample(8'd254);
    drain_pipeline();
  endtask

  // Random phases: fresh levels each phase, then bursts of random samples
  // with random gaps. Every third phase streams with no gaps at all, and
  // each phase drains once in the middle to empty the pipeline under load.
  task automatic test_random_stream();
    int unsigned phase;
    int unsigned sent;
    int unsigned burst;
    int unsigned drain_at;
    for (phase = 0; phase < RandPhases; phase++) begin
      write_all_levels(pick_level(), pick_level(), pick_level());
      if ($urandom_range(0, 2) == 0) begin
        write_level(RegUnused, 8'($urandom));
      end
      sent     = 0;
      drain_at = $urandom_range(20, PhaseSamples - 20);
      while (sent < PhaseSamples) begin
        burst = $urandom_range(1, 30);
        while (burst > 0 && sent < PhaseSamples) begin
          send_sample(pick_sample());
          sent++;
          burst--;
          if (sent == drain_at) begin
            drain_pipeline();
          end
        end
        if (phase % 3 != 0) begin
          sender_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
        end
      end
      drain_pipeline();
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    sample_in_i    <= 8'd0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= RegBrightness;
    cfg_wdata_i    <= 8'd0;
    brightness_lvl  = 8'(LevelMid);
    contrast_lvl    = 8'(LevelMid);
    saturation_lvl  = 8'(LevelMid);
    failures        = 0;
    samples_sent    = 0;
    pixels_checked  = 0;
    level_writes    = 0;
    cycle_count     = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_neutral_levels();
    test_level_extremes();
    test_unused_index();
    test_random_stream();

    $display("covered %0d samples, %0d checked pixels, %0d level writes",
             samples_sent, pixels_checked, level_writes);
    $display("levels swept across extremes, neutral and random values, with gaps and drains");
    if (failures == 0) begin
      $display("[video_luma_chroma_adjust] OK");
    end else begin
      $display("[video_luma_chroma_adjust] ERROR");
    end
    $finish;
  end

endmodule

// ===== video_luma_chroma_adjust.f =====
hw/rtl/lcadj_pkg.sv
hw/rtl/lcadj_gain.sv
hw/rtl/video_luma_chroma_adjust.sv
tb/sv/video_luma_chroma_adjust_tb.sv
